// File: hdl/mbf_pkg.sv
// Shared types and constants for the modular binomial block.
// No dependencies; the multiplier and the top level both use it.
package mbf_pkg;

    localparam int N_WIDTH = 16;
    localparam int P_WIDTH = 31;

    // The serial multiplier walks the bits of its first operand, which is
    // either an index value or a residue.
    localparam int MUL_A_WIDTH = (N_WIDTH > P_WIDTH) ? N_WIDTH : P_WIDTH;
    localparam int MUL_CNT_WIDTH = $clog2(MUL_A_WIDTH);

    localparam logic [P_WIDTH-1:0] MODULUS_RESET = P_WIDTH'(64'd1000000007);

    typedef struct packed {
        logic [N_WIDTH-1:0] n_value;
        logic [N_WIDTH-1:0] r_value;
    } in_item_t;

    typedef struct packed {
        logic [P_WIDTH-1:0] coefficient;
        logic               out_of_range;
        logic               denominator_zero;
    } out_item_t;

    typedef struct packed {
        logic                   start;
        logic [MUL_A_WIDTH-1:0] a;
        logic [P_WIDTH-1:0]     b;
    } mul_req_t;

    typedef struct packed {
        logic               done;
        logic [P_WIDTH-1:0] product;
    } mul_rsp_t;

endpackage

// File: hdl/mbf_mulmod.sv
// Bit-serial modular multiplier: a * b mod p, one bit of a per cycle, MSB first.
// Depends on mbf_pkg. Requires b < p; a may be any value of its width.
module mbf_mulmod (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [mbf_pkg::P_WIDTH-1:0]  modulus,
    input  mbf_pkg::mul_req_t            req,
    output mbf_pkg::mul_rsp_t            rsp
);

    logic                              busy_reg;
    logic                              done_reg;
    logic [mbf_pkg::MUL_CNT_WIDTH-1:0] cnt_reg;
    logic [mbf_pkg::MUL_A_WIDTH-1:0]   a_reg;
    logic [mbf_pkg::P_WIDTH-1:0]       b_reg;
    logic [mbf_pkg::P_WIDTH-1:0]       acc_reg;
    logic [mbf_pkg::P_WIDTH-1:0]       acc_next;

    logic [mbf_pkg::P_WIDTH:0] p_ext;
    logic [mbf_pkg::P_WIDTH:0] dbl;
    logic [mbf_pkg::P_WIDTH:0] dbl_red;
    logic [mbf_pkg::P_WIDTH:0] sum;
    logic [mbf_pkg::P_WIDTH:0] sum_red;

    // acc = 2*acc + bit*b, kept below p by two conditional subtracts
    always_comb
    begin
        p_ext   = {1'b0, modulus};
        dbl     = {acc_reg, 1'b0};
        dbl_red = (dbl >= p_ext) ? (dbl - p_ext) : dbl;
        sum     = dbl_red + (a_reg[mbf_pkg::MUL_A_WIDTH-1] ? {1'b0, b_reg} : '0);
        sum_red = (sum >= p_ext) ? (sum - p_ext) : sum;
        acc_next = sum_red[mbf_pkg::P_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == mbf_pkg::MUL_CNT_WIDTH'(mbf_pkg::MUL_A_WIDTH - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg   <= req.a;
            b_reg   <= req.b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            a_reg   <= {a_reg[mbf_pkg::MUL_A_WIDTH-2:0], 1'b0};
            acc_reg <= acc_next;
        end
    end

    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

endmodule

// File: hdl/modular_binomial_fermat.sv
// Top level: C(n, r) mod p with the inverse of r! taken by Fermat's theorem.
// Depends on mbf_pkg and mbf_mulmod (the one shared serial multiplier).
//
//  channel   | signals                           | transfer when
//  ----------+-----------------------------------+----------------------------
//  input     | in_valid, in_ready, in_data       | in_valid & in_ready
//  output    | out_valid, out_ready, out_data    | out_valid & out_ready
//  config    | cfg_wr_en, cfg_wr_data (modulus)  | cfg_wr_en (no wait)
//
// Each product runs on the one serial multiplier. With r' = min(r, n - r),
// the block does r' num and den product pairs, then a square per bit and a
// multiply per one bit of p - 2, then the final product; r! = 0 mod p,
// r > n and p < 2 skip to the flag result. One item is in work at a time; a
// result held while out_ready is low stalls the next in ST_OUT.
// Reset sets the modulus to 1000000007 and clears all control state.
module modular_binomial_fermat (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  mbf_pkg::in_item_t           in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output mbf_pkg::out_item_t          out_data,
    input  logic                        cfg_wr_en,
    input  logic [mbf_pkg::P_WIDTH-1:0] cfg_wr_data
);

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_LOOP     = 9'b000000010,
        ST_NUM_WAIT = 9'b000000100,
        ST_DEN_WAIT = 9'b000001000,
        ST_POW      = 9'b000010000,
        ST_ACC_WAIT = 9'b000100000,
        ST_SQR_WAIT = 9'b001000000,
        ST_FIN_WAIT = 9'b010000000,
        ST_OUT      = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [mbf_pkg::P_WIDTH-1:0] modulus_reg;

    // Per-item working registers
    logic [mbf_pkg::N_WIDTH-1:0] n_reg;
    logic [mbf_pkg::N_WIDTH-1:0] r_lim_reg;
    logic [mbf_pkg::N_WIDTH-1:0] i_reg;
    logic [mbf_pkg::P_WIDTH-1:0] num_reg;
    logic [mbf_pkg::P_WIDTH-1:0] den_reg;
    logic [mbf_pkg::P_WIDTH-1:0] acc_reg;
    logic [mbf_pkg::P_WIDTH-1:0] base_reg;
    logic [mbf_pkg::P_WIDTH-1:0] exp_reg;
    mbf_pkg::out_item_t          res_reg;

    // Output register
    logic                        out_valid_reg;
    mbf_pkg::out_item_t          out_data_reg;

    mbf_pkg::mul_req_t mul_req;
    mbf_pkg::mul_rsp_t mul_rsp;

    logic                        in_xfer;
    logic                        out_free;
    logic [mbf_pkg::N_WIDTH-1:0] diff;
    logic [mbf_pkg::N_WIDTH-1:0] r_lim;
    logic                        p_small;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign diff      = in_data.n_value - in_data.r_value;
    assign r_lim     = (diff < in_data.r_value) ? diff : in_data.r_value;
    assign p_small   = (modulus_reg < mbf_pkg::P_WIDTH'(2));
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    mbf_mulmod u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .modulus (modulus_reg),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    // Sequencer: issue one product at a time, advance on its done pulse
    always_comb
    begin
        state_next    = state_reg;
        mul_req.start = 1'b0;
        mul_req.a     = '0;
        mul_req.b     = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (in_data.r_value > in_data.n_value || p_small)
                        state_next = ST_OUT;
                    else
                        state_next = ST_LOOP;
                end
            end
            ST_LOOP:
            begin
                if (i_reg == r_lim_reg)
                begin
                    // Drop to the flag result when r! vanishes mod p
                    state_next = (den_reg == '0) ? ST_OUT : ST_POW;
                end
                else
                begin
                    // num *= (n - i)
                    mul_req.start = 1'b1;
                    mul_req.a     = mbf_pkg::MUL_A_WIDTH'(n_reg - i_reg);
                    mul_req.b     = num_reg;
                    state_next    = ST_NUM_WAIT;
                end
            end
            ST_NUM_WAIT:
            begin
                if (mul_rsp.done)
                begin
                    // den *= (i + 1)
                    mul_req.start = 1'b1;
                    mul_req.a     = mbf_pkg::MUL_A_WIDTH'(i_reg + 1'b1);
                    mul_req.b     = den_reg;
                    state_next    = ST_DEN_WAIT;
                end
            end
            ST_DEN_WAIT:
            begin
                if (mul_rsp.done)
                    state_next = ST_LOOP;
            end
            ST_POW:
            begin
                if (exp_reg == '0)
                begin
                    // coefficient = num * den^(p-2)
                    mul_req.start = 1'b1;
                    mul_req.a     = mbf_pkg::MUL_A_WIDTH'(num_reg);
                    mul_req.b     = acc_reg;
                    state_next    = ST_FIN_WAIT;
                end
                else if (exp_reg[0])
                begin
                    mul_req.start = 1'b1;
                    mul_req.a     = mbf_pkg::MUL_A_WIDTH'(acc_reg);
                    mul_req.b     = base_reg;
                    state_next    = ST_ACC_WAIT;
                end
                else
                begin
                    mul_req.start = 1'b1;
                    mul_req.a     = mbf_pkg::MUL_A_WIDTH'(base_reg);
                    mul_req.b     = base_reg;
                    state_next    = ST_SQR_WAIT;
                end
            end
            ST_ACC_WAIT:
            begin
                if (mul_rsp.done)
                begin
                    // Square the base with the old value, not the new acc
                    mul_req.start = 1'b1;
                    mul_req.a     = mbf_pkg::MUL_A_WIDTH'(base_reg);
                    mul_req.b     = base_reg;
                    state_next    = ST_SQR_WAIT;
                end
            end
            ST_SQR_WAIT:
            begin
                if (mul_rsp.done)
                    state_next = ST_POW;
            end
            ST_FIN_WAIT:
            begin
                if (mul_rsp.done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            modulus_reg   <= mbf_pkg::MODULUS_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
                modulus_reg <= cfg_wr_data;
            // Hold the result until the output transfer completes
            if (state_reg == ST_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers follow the sequencer; no reset needed
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT && out_free)
            out_data_reg <= res_reg;

        unique case (state_reg) inside
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    n_reg     <= in_data.n_value;
                    r_lim_reg <= r_lim;
                    i_reg     <= '0;
                    num_reg   <= mbf_pkg::P_WIDTH'(1);
                    den_reg   <= mbf_pkg::P_WIDTH'(1);
                    res_reg.coefficient      <= '0;
                    res_reg.out_of_range     <= (in_data.r_value > in_data.n_value);
                    res_reg.denominator_zero <= !(in_data.r_value > in_data.n_value)
                                                && p_small;
                end
            end
            ST_LOOP:
            begin
                if (i_reg == r_lim_reg)
                begin
                    res_reg.denominator_zero <= (den_reg == '0);
                    acc_reg  <= mbf_pkg::P_WIDTH'(1);
                    base_reg <= den_reg;
                    exp_reg  <= modulus_reg - mbf_pkg::P_WIDTH'(2);
                end
            end
            ST_NUM_WAIT:
            begin
                if (mul_rsp.done)
                    num_reg <= mul_rsp.product;
            end
            ST_DEN_WAIT:
            begin
                if (mul_rsp.done)
                begin
                    den_reg <= mul_rsp.product;
                    i_reg   <= i_reg + 1'b1;
                end
            end
            ST_ACC_WAIT:
            begin
                if (mul_rsp.done)
                    acc_reg <= mul_rsp.product;
            end
            ST_SQR_WAIT:
            begin
                if (mul_rsp.done)
                begin
                    base_reg <= mul_rsp.product;
                    exp_reg  <= exp_reg >> 1;
                end
            end
            ST_FIN_WAIT:
            begin
                if (mul_rsp.done)
                    res_reg.coefficient <= mul_rsp.product;
            end
            ST_POW, ST_OUT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // A product finishes only while the sequencer waits for one
    a_mul_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mul_rsp.done |-> (state_reg == ST_NUM_WAIT || state_reg == ST_DEN_WAIT ||
                          state_reg == ST_ACC_WAIT || state_reg == ST_SQR_WAIT ||
                          state_reg == ST_FIN_WAIT))
        else $error("multiplier done outside a wait state");

    // The falling-product index never runs past the reduced r
    a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOP) |-> (i_reg <= r_lim_reg))
        else $error("loop index beyond limit");

    // A flagged result carries a zero coefficient, and only one flag is raised
    a_flag_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!(out_data_reg.out_of_range && out_data_reg.denominator_zero) &&
            (!(out_data_reg.out_of_range || out_data_reg.denominator_zero) ||
             out_data_reg.coefficient == '0)))
        else $error("inconsistent result flags");

    // An accepted item always leaves the idle state
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg != ST_IDLE))
        else $error("input transfer did not start work");

endmodule

// File: tb/sv/mbf_result_check.sv
// Checker for modular_binomial_fermat: predicts C(n, r) mod p for every input
// transfer and compares each output transfer with the oldest prediction.
// Depends on mbf_pkg for the item types, widths and the modulus reset value.
module mbf_result_check
    import mbf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  in_item_t           in_data,
    input  logic               out_valid,
    input  logic               out_ready,
    input  out_item_t          out_data,
    input  logic               cfg_wr_en,
    input  logic [P_WIDTH-1:0] cfg_wr_data,
    output int                 mismatch_count,
    output int                 open_results
);

    logic [P_WIDTH-1:0] modulus_copy;
    out_item_t          expected_residues[$];

    // C(n, r) mod p with the inverse of r! taken as (r!)^(p-2).
    function automatic out_item_t binomial_residue(
        input logic [N_WIDTH-1:0] n_in,
        input logic [N_WIDTH-1:0] r_in,
        input logic [P_WIDTH-1:0] p_in
    );
        longint unsigned n;
        longint unsigned k;
        longint unsigned p;
        longint unsigned num;
        longint unsigned den;
        longint unsigned base;
        longint unsigned ex;
        longint unsigned inv;
        longint unsigned i;
        out_item_t       res;
        n   = n_in;
        k   = r_in;
        p   = p_in;
        res = '0;
        if (k > n)
            res.out_of_range = 1'b1;
        else if (p < 2)
            res.denominator_zero = 1'b1;
        else
        begin
            if (n - k < k)
                k = n - k;
            num = 1;
            den = 1;
            for (i = 0; i < k; i++)
            begin
                num = (num * ((n - i) % p)) % p;
                den = (den * ((i + 1) % p)) % p;
            end
            if (den == 0)
                res.denominator_zero = 1'b1;
            else
            begin
                inv  = 1;
                base = den;
                ex   = p - 2;
                while (ex != 0)
                begin
                    if (ex[0])
                        inv = (inv * base) % p;
                    base = (base * base) % p;
                    ex   = ex >> 1;
                end
                res.coefficient = P_WIDTH'((num * inv) % p);
            end
        end
        return res;
    endfunction

    task automatic compare_field(input string field, input longint unsigned want,
                                 input longint unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_copy   <= MODULUS_RESET;
            mismatch_count = 0;
            expected_residues.delete();
            open_results   <= 0;
        end
        else
        begin
            // retire first so a stray output is never matched by a same-edge input
            if (out_valid && out_ready)
            begin
                if (expected_residues.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual coef %0d oor %0b dz %0b",
                             $time, out_data.coefficient, out_data.out_of_range,
                             out_data.denominator_zero);
                    mismatch_count++;
                end
                else
                begin
                    out_item_t want;
                    want = expected_residues.pop_front();
                    compare_field("coefficient", want.coefficient, out_data.coefficient);
                    compare_field("out_of_range", want.out_of_range, out_data.out_of_range);
                    compare_field("denominator_zero", want.denominator_zero,
                                  out_data.denominator_zero);
                end
            end
            if (in_valid && in_ready)
                expected_residues.push_back(binomial_residue(in_data.n_value,
                                                             in_data.r_value, modulus_copy));
            if (cfg_wr_en)
                modulus_copy <= cfg_wr_data;
            open_results <= expected_residues.size();
        end
    end

endmodule

// File: tb/sv/modular_binomial_fermat_tb.sv
// Testbench top for modular_binomial_fermat: drives n/r items and modulus
// writes, randomly stalls both channels, and reports the verdict.
// Depends on mbf_pkg, modular_binomial_fermat and mbf_result_check.
module modular_binomial_fermat_tb;
    import mbf_pkg::*;

    localparam logic [N_WIDTH-1:0] N_MAX = '1;

    // Worst legal run: about 125 items of r' <= 100, plus five wide items of
    // r' <= 800, plus stalls. CYCLE_LIMIT must stay above that run; past it the
    // bench calls it a hang.
    localparam int CYCLE_LIMIT = 4_000_000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    in_item_t           in_data;
    logic               out_valid;
    logic               out_ready;
    out_item_t          out_data;
    logic               cfg_wr_en;
    logic [P_WIDTH-1:0] cfg_wr_data;

    int mismatch_count;
    int open_results;
    int cycle_count = 0;

    // When low, both channels run flat out: no sender gaps, no receiver stalls.
    bit stall_enable;

    modular_binomial_fermat dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    mbf_result_check check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .mismatch_count (mismatch_count),
        .open_results   (open_results)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Hang guard: a correct run never gets near the limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Drop out_ready with a chance of about 18 in a hundred while stalls are enabled.
    // Redrawn every cycle, so stalls land on every phase of the block's work.
    always @(posedge clk)
        out_ready <= !stall_enable || ($urandom_range(99) >= 18);

    // Present one item and hold it until the transfer. On return we sit in the
    // time step of the transfer edge with in_valid still high; the next call
    // either keeps it high (back to back) or drops it for a gap.
    task automatic send_item(input logic [N_WIDTH-1:0] n, input logic [N_WIDTH-1:0] r);
        while (stall_enable && $urandom_range(99) < 18)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        in_data.n_value <= n;
        in_data.r_value <= r;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Write the modulus only with the block idle: drop valid, let every
    // predicted result drain, give the block a short pause, then write.
    task automatic load_modulus(input logic [P_WIDTH-1:0] p, input bit stalls);
        in_valid <= 1'b0;
        @(posedge clk);
        while (open_results != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_data  <= p;
        stall_enable <= stalls;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly well-formed items with a small r' = min(r, n - r) so the block
    // stays fast; one item in ten has r above n. Wide items push r' into the
    // hundreds to exercise long product chains.
    function automatic in_item_t random_item(input bit wide);
        int unsigned n;
        int unsigned k;
        in_item_t    item;
        n = $urandom_range(N_MAX);
        k = wide ? $urandom_range(800, 200) : $urandom_range(40, 0);
        case ($urandom_range(9))
            0:
            begin
                n = $urandom_range(N_MAX - 1);
                item.n_value = N_WIDTH'(n);
                item.r_value = N_WIDTH'($urandom_range(N_MAX, n + 1));
            end
            1, 2, 3, 4:
            begin
                item.n_value = N_WIDTH'(n);
                item.r_value = N_WIDTH'((k <= n) ? k : n);
            end
            default:
            begin
                // r close to n: high bits of r follow n, folded onto small r'
                item.n_value = N_WIDTH'(n);
                item.r_value = N_WIDTH'((k <= n) ? n - k : n);
            end
        endcase
        return item;
    endfunction

    task automatic random_phase(input logic [P_WIDTH-1:0] p, input int count, input bit stalls);
        int       idx;
        in_item_t item;
        load_modulus(p, stalls);
        for (idx = 0; idx < count; idx++)
        begin
            item = random_item(idx == count / 2);
            send_item(item.n_value, item.r_value);
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        out_ready    = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        stall_enable = 1'b1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset modulus 1000000007: field extremes, symmetric folding, r above n.
        send_item(0, 0);
        send_item(N_MAX, 0);
        send_item(N_MAX, N_MAX);
        send_item(0, N_MAX);
        send_item(N_MAX - 1, N_MAX);
        send_item(N_MAX, 1);
        send_item(N_MAX, N_MAX - 1);
        send_item(52, 5);
        send_item(40, 20);
        send_item(N_MAX, N_MAX - 32);

        // Largest modulus, full 31-bit products and the longest exponent.
        load_modulus(P_WIDTH'(2147483647), 1'b1);
        send_item(N_MAX, N_MAX - 7);
        send_item(200, 100);

        // Smallest prime: exponent p-2 is zero, so the inverse is one.
        load_modulus(P_WIDTH'(2), 1'b1);
        send_item(1, 1);
        send_item(3, 1);
        send_item(5, 2);
        send_item(0, 0);

        // Modulus below two: every r <= n flags a zero denominator.
        load_modulus(P_WIDTH'(0), 1'b1);
        send_item(5, 2);
        send_item(2, 5);
        load_modulus(P_WIDTH'(1), 1'b1);
        send_item(0, 0);
        send_item(N_MAX, N_MAX);

        // Small prime: r! reaches a multiple of p.
        load_modulus(P_WIDTH'(7), 1'b1);
        send_item(20, 10);
        send_item(10, 3);

        // Composite modulus: the same steps, no special handling.
        load_modulus(P_WIDTH'(12), 1'b1);
        send_item(10, 4);
        send_item(6, 3);

        // Random part; the second phase runs with no idling on either side.
        random_phase(P_WIDTH'(1000000007), 20, 1'b1);
        random_phase(P_WIDTH'(13), 20, 1'b0);
        random_phase(P_WIDTH'(2147483647), 20, 1'b1);
        random_phase(P_WIDTH'(65537), 20, 1'b1);
        random_phase(P_WIDTH'($urandom()), 20, 1'b1);

        // Drain: wait out every prediction, then a short tail for strays.
        in_valid <= 1'b0;
        @(posedge clk);
        while (open_results != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (mismatch_count == 0 && open_results == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: sim.f
hdl/mbf_pkg.sv
hdl/mbf_mulmod.sv
hdl/modular_binomial_fermat.sv
tb/sv/mbf_result_check.sv
tb/sv/modular_binomial_fermat_tb.sv
